// ===== hdl/vmx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the instruction execute block.
package vmx_pkg;

  localparam int unsigned NUM_REGS = 16;
  localparam int unsigned REG_AW   = $clog2(NUM_REGS);
  localparam int unsigned REG_DW   = 8;
  localparam int unsigned PC_W     = 16;
  localparam int unsigned IDX_W    = 12;

  localparam logic [PC_W-1:0] PC_START = 16'h0200;
  localparam logic [PC_W-1:0] PC_STEP  = 16'd2;

  typedef enum logic [1:0] {
    REQ_EXEC  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    OP_JP      = 4'h1,
    OP_SE_IMM  = 4'h3,
    OP_SNE_IMM = 4'h4,
    OP_SE_REG  = 4'h5,
    OP_LD_IMM  = 4'h6,
    OP_ADD_IMM = 4'h7,
    OP_SNE_REG = 4'h9,
    OP_LD_IDX  = 4'hA,
    OP_JP_V0   = 4'hB
  } op_e;

  localparam logic [REG_AW-1:0] REG_V0 = '0;

endpackage

// ===== hdl/vm_instruction_execute_subset.sv =====
`timescale 1ns / 1ps
// Top level of the instruction execute block with its register file memory.

// Executes one request per cycle unless stalled: an execute transaction takes a 16-bit
// instruction word fetched at next_pc_o, and write and read transactions access the
// sixteen 8-bit general registers. A transaction enters while the general register file,
// a small synchronous memory with two read ports, is read into the execute stage registers;
// the execute stage then evaluates it, writes the register back and loads the result
// register, which presents the result, and a new transaction is accepted every cycle while
// the block does not stall. Back-to-back accesses to the same register are served by
// forwarding the write data into the read data register. The register file reads as zero
// after reset until each entry is written; the block accepts transactions right after reset
// and stalls only when the result register is full and not being taken.
module vm_instruction_execute_subset (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  req_type_i,
  input  logic [15:0]                 instr_word_i,
  input  logic [vmx_pkg::REG_AW-1:0]  reg_index_i,
  input  logic [vmx_pkg::REG_DW-1:0]  reg_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [vmx_pkg::PC_W-1:0]    next_pc_o,
  output logic [vmx_pkg::IDX_W-1:0]   index_value_o,
  output logic [vmx_pkg::REG_DW-1:0]  read_value_o,
  output logic                        status_o
);
  import vmx_pkg::*;

  // Register file storage and its per-entry written flags.
  logic [REG_DW-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0] written_q;

  // Execute stage registers.
  logic              s1_valid_q;
  req_e              s1_req_q;
  logic [15:0]       s1_word_q;
  logic [REG_AW-1:0] s1_addr_q;
  logic [REG_DW-1:0] s1_value_q;
  logic [REG_DW-1:0] rd_a_q, rd_b_q;

  // Architectural registers.
  logic [PC_W-1:0]  pc_q, pc_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  // Result register.
  logic              out_valid_q;
  logic [PC_W-1:0]   out_pc_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [REG_DW-1:0] out_rd_q;
  logic              out_st_q;

  logic              in_fire, s1_go;
  logic [REG_AW-1:0] addr_a, addr_b;
  logic              wr_en, wr_fire;
  logic [REG_DW-1:0] wr_data;
  logic [REG_DW-1:0] rd_val;
  logic              status;
  logic              skip;
  logic [3:0]        op;
  logic [REG_DW-1:0] nn;
  logic [IDX_W-1:0]  nnn;
  logic [PC_W-1:0]   pc_inc, pc_inc2;

  assign s1_go      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_fire    = in_valid_i && in_ready_o;

  // Port A serves X of an instruction or the register of a side request; port B serves Y,
  // or V0 for a jump with offset.
  always_comb begin
    addr_a = (req_type_i == REQ_EXEC) ? instr_word_i[11:8] : reg_index_i;
    addr_b = (instr_word_i[15:12] == OP_JP_V0) ? REG_V0 : instr_word_i[7:4];
  end

  assign wr_fire = s1_go && wr_en;

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem[s1_addr_q] <= wr_data;
    end
    if (in_fire) begin
      if (wr_fire && (s1_addr_q == addr_a)) begin
        rd_a_q <= wr_data;
      end else begin
        rd_a_q <= written_q[addr_a] ? mem[addr_a] : '0;
      end
      if (wr_fire && (s1_addr_q == addr_b)) begin
        rd_b_q <= wr_data;
      end else begin
        rd_b_q <= written_q[addr_b] ? mem[addr_b] : '0;
      end
      s1_req_q   <= req_e'(req_type_i);
      s1_word_q  <= instr_word_i;
      s1_addr_q  <= addr_a;
      s1_value_q <= reg_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_fire) begin
      written_q[s1_addr_q] <= 1'b1;
    end
  end

  always_comb begin
    op      = s1_word_q[15:12];
    nn      = s1_word_q[7:0];
    nnn     = s1_word_q[11:0];
    pc_inc  = pc_q + PC_STEP;
    pc_inc2 = pc_q + (PC_STEP << 1);
    pc_d    = pc_q;
    idx_d   = idx_q;
    wr_en   = 1'b0;
    wr_data = s1_value_q;
    rd_val  = '0;
    status  = 1'b0;
    skip    = 1'b0;
    case (s1_req_q)
      REQ_EXEC: begin
        pc_d = pc_inc;
        case (op)
          OP_JP:      pc_d = {{(PC_W-IDX_W){1'b0}}, nnn};
          OP_SE_IMM:  skip = (rd_a_q == nn);
          OP_SNE_IMM: skip = (rd_a_q != nn);
          OP_SE_REG: begin
            if (s1_word_q[3:0] != 4'h0) begin
              status = 1'b1;
            end else begin
              skip = (rd_a_q == rd_b_q);
            end
          end
          OP_SNE_REG: begin
            if (s1_word_q[3:0] != 4'h0) begin
              status = 1'b1;
            end else begin
              skip = (rd_a_q != rd_b_q);
            end
          end
          OP_LD_IMM: begin
            wr_en   = 1'b1;
            wr_data = nn;
          end
          OP_ADD_IMM: begin
            wr_en   = 1'b1;
            wr_data = rd_a_q + nn;
          end
          OP_LD_IDX:  idx_d = nnn;
          OP_JP_V0: begin
            pc_d = {{(PC_W-IDX_W){1'b0}}, nnn} + {{(PC_W-REG_DW){1'b0}}, rd_b_q};
          end
          default: ;
        endcase
        if (skip) begin
          pc_d = pc_inc2;
        end
      end
      REQ_WRITE: wr_en = 1'b1;
      REQ_READ:  rd_val = rd_a_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= PC_START;
      idx_q       <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
        pc_q        <= pc_d;
        idx_q       <= idx_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_pc_q  <= pc_d;
      out_idx_q <= idx_d;
      out_rd_q  <= rd_val;
      out_st_q  <= status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_pc_o     = out_pc_q;
  assign index_value_o = out_idx_q;
  assign read_value_o  = out_rd_q;
  assign status_o      = out_st_q;

  // A transaction leaving the execute stage always lands in the result register.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go |=> out_valid_o)
    else $error("execute stage advanced without loading the result register");

  // Register write and read requests never move the program counter.
  a_side_keeps_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && (s1_req_q != REQ_EXEC)) |=> (pc_q == $past(pc_q)))
    else $error("side request changed the program counter");

  // A stalled execute stage must block new transactions.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |-> !in_ready_o)
    else $error("input accepted while execute stage stalled");

  // Only execute transactions of the register compare groups can report invalid.
  a_status_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && status) |-> ((s1_req_q == REQ_EXEC) &&
                           ((op == OP_SE_REG) || (op == OP_SNE_REG))))
    else $error("invalid status from an unexpected request");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the instruction execute block.
module tb_top;
  import vmx_pkg::*;

  // Request code the block leaves unused; it must report state and change nothing.
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1380;

  typedef struct {
    logic [1:0]        kind;
    logic [15:0]       word;
    logic [REG_AW-1:0] rnum;
    logic [REG_DW-1:0] wdata;
    bit                drain;
  } request_t;

  typedef struct {
    logic [PC_W-1:0]   pc;
    logic [IDX_W-1:0]  idx;
    logic [REG_DW-1:0] rdata;
    logic              status;
  } outcome_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready_o;
  logic [1:0]        req_type = '0;
  logic [15:0]       instr_word = '0;
  logic [REG_AW-1:0] reg_index = '0;
  logic [REG_DW-1:0] reg_value = '0;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  logic [PC_W-1:0]   next_pc_o;
  logic [IDX_W-1:0]  index_value_o;
  logic [REG_DW-1:0] read_value_o;
  logic              status_o;

  vm_instruction_execute_subset uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type),
    .instr_word_i (instr_word),
    .reg_index_i  (reg_index),
    .reg_value_i  (reg_value),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .next_pc_o    (next_pc_o),
    .index_value_o(index_value_o),
    .read_value_o (read_value_o),
    .status_o     (status_o)
  );

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];

  // Shadow machine state.
  logic [REG_DW-1:0] vm_gpr[NUM_REGS];
  logic [PC_W-1:0]   vm_pc = PC_START;
  logic [IDX_W-1:0]  vm_idx = '0;

  int unsigned items_taken = 0;
  int unsigned mismatches = 0;
  bit          in_taken = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned phase_left = 0;
  int unsigned stall_mode = 0;
  int unsigned hold_points[$] = '{400, 1000};

  initial begin
    for (int i = 0; i < NUM_REGS; i++) vm_gpr[i] = '0;
  end

  // Advances the shadow machine by one request and returns what the block must report.
  function automatic outcome_t execute_request(input request_t rq);
    logic [3:0]        x;
    logic [3:0]        y;
    logic [7:0]        nn;
    logic [11:0]       nnn;
    logic [REG_DW-1:0] vx;
    logic [REG_DW-1:0] vy;
    bit                skip;
    outcome_t          res;
    x = rq.word[11:8];
    y = rq.word[7:4];
    nn = rq.word[7:0];
    nnn = rq.word[11:0];
    vx = vm_gpr[x];
    vy = vm_gpr[y];
    skip = 1'b0;
    res.rdata = '0;
    res.status = 1'b0;
    case (rq.kind)
      REQ_EXEC: begin
        vm_pc = vm_pc + PC_STEP;
        case (rq.word[15:12])
          OP_JP:      vm_pc = {4'h0, nnn};
          OP_SE_IMM:  skip = (vx == nn);
          OP_SNE_IMM: skip = (vx != nn);
          OP_SE_REG: begin
            if (rq.word[3:0] != 4'h0) res.status = 1'b1;
            else skip = (vx == vy);
          end
          OP_LD_IMM:  vm_gpr[x] = nn;
          OP_ADD_IMM: vm_gpr[x] = vx + nn;
          OP_SNE_REG: begin
            if (rq.word[3:0] != 4'h0) res.status = 1'b1;
            else skip = (vx != vy);
          end
          OP_LD_IDX:  vm_idx = nnn;
          OP_JP_V0:   vm_pc = {4'h0, nnn} + {8'h00, vm_gpr[REG_V0]};
          default: ;
        endcase
        if (skip) vm_pc = vm_pc + PC_STEP;
      end
      REQ_WRITE: vm_gpr[rq.rnum] = rq.wdata;
      REQ_READ:  res.rdata = vm_gpr[rq.rnum];
      default: ;
    endcase
    res.pc = vm_pc;
    res.idx = vm_idx;
    return res;
  endfunction

  function automatic void add_request(input logic [1:0] kind, input logic [15:0] word,
                                      input logic [3:0] rnum, input logic [7:0] wdata,
                                      input bit drain = 1'b0);
    request_t rq;
    rq.kind = kind;
    rq.word = word;
    rq.rnum = rnum;
    rq.wdata = wdata;
    rq.drain = drain;
    pending_requests.push_back(rq);
  endfunction

  // Bytes from a narrow pool so that compares against registers hit often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7F;
      3, 4: return 8'($urandom_range(0, 3));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_instr();
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] n;
    logic [7:0] nn;
    x = 4'($urandom);
    y = ($urandom_range(0, 3) == 0) ? x : 4'($urandom);
    n = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(1, 15)) : 4'h0;
    nn = pick_byte();
    case ($urandom_range(0, 12))
      0:     return {OP_JP, x, nn};
      1, 2:  return {OP_SE_IMM, x, nn};
      3, 4:  return {OP_SNE_IMM, x, nn};
      5:     return {OP_SE_REG, x, y, n};
      6:     return {OP_SNE_REG, x, y, n};
      7:     return {OP_LD_IMM, x, nn};
      8:     return {OP_ADD_IMM, x, nn};
      9:     return {OP_LD_IDX, x, 8'($urandom)};
      10:    return {OP_JP_V0, x, 8'($urandom)};
      default: begin
        // Groups without an implementation.
        case ($urandom_range(0, 6))
          0: return {4'h0, 12'($urandom)};
          1: return {4'h2, 12'($urandom)};
          2: return {4'h8, 12'($urandom)};
          3: return {4'hC, 12'($urandom)};
          4: return {4'hD, 12'($urandom)};
          5: return {4'hE, 12'($urandom)};
          default: return {4'hF, 12'($urandom)};
        endcase
      end
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stimulus and end of run.
  initial begin
    int unsigned pick;
    add_request(REQ_READ, 16'h0000, 4'hF, 8'h00);
    add_request(REQ_EXEC, 16'h60FF, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'h7001, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'h7FFF, 4'h0, 8'h00);
    add_request(REQ_WRITE, 16'hFFFF, 4'h0, 8'h80);
    add_request(REQ_READ, 16'h0000, 4'hF, 8'hFF);
    add_request(REQ_EXEC, 16'h3FFF, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'h3F00, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'h4FFF, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'h4F00, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'h5F00, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'h5FF0, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'h9F00, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'h9FF0, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'h5001, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'h9FFF, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'hAFFF, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'hA000, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'hBFFF, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'h1FFF, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'h1000, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'h0000, 4'hF, 8'hFF);
    add_request(REQ_EXEC, 16'h8ABC, 4'h0, 8'h00);
    add_request(REQ_EXEC, 16'hFFFF, 4'h0, 8'h00);
    add_request(REQ_NONE, 16'hFFFF, 4'hF, 8'hFF);
    add_request(REQ_WRITE, 16'h0000, 4'hF, 8'h00, 1'b1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) add_request(REQ_EXEC, random_instr(), 4'($urandom), 8'($urandom));
      else if (pick < 70) add_request(REQ_WRITE, 16'($urandom), 4'($urandom), pick_byte());
      else if (pick < 90) add_request(REQ_READ, 16'($urandom), 4'($urandom), 8'($urandom));
      else if (pick < 95) add_request(REQ_NONE, 16'($urandom), 4'($urandom), 8'($urandom));
      else add_request(REQ_EXEC, 16'($urandom), 4'($urandom), 8'($urandom), i == 700);
    end

    // Jump as high as the instruction set allows, then carry on with random instructions.
    add_request(REQ_WRITE, 16'h0000, REG_V0, 8'hFF, 1'b1);
    add_request(REQ_EXEC, 16'hBFFF, 4'h0, 8'h00);
    for (int i = 0; i < 40; i++) begin
      add_request(REQ_EXEC, random_instr(), 4'($urandom), 8'($urandom));
    end

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (pending_requests.size() != 0 || expected_outcomes.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #7ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Sender: bursts of transactions separated by random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() == 0 ||
                   (pending_requests[0].drain && expected_outcomes.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        req_type <= pending_requests[0].kind;
        instr_word <= pending_requests[0].word;
        reg_index <= pending_requests[0].rnum;
        reg_value <= pending_requests[0].wdata;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: stall density changes from phase to phase, with long holds at set points.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_points.size() != 0 && items_taken >= hold_points[0]) begin
        void'(hold_points.pop_front());
        out_ready <= 1'b0;
        hold_left <= 60;
      end else begin
        if (phase_left == 0) begin
          stall_mode <= $urandom_range(0, 3);
          phase_left <= $urandom_range(20, 80);
        end else begin
          phase_left <= phase_left - 1;
        end
        out_ready <= ($urandom_range(0, 3) >= stall_mode);
      end
    end
  end

  task automatic report_failure(input string what, input outcome_t want, input outcome_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%t %s: expected pc=%h idx=%h rd=%h st=%b, got pc=%h idx=%h rd=%h st=%b",
               $realtime, what, want.pc, want.idx, want.rdata, want.status,
               got.pc, got.idx, got.rdata, got.status);
    end
  endtask

  // Accepted requests feed the predictor; delivered results are checked in order.
  always @(posedge clk_i) begin
    outcome_t want;
    outcome_t got;
    in_taken <= rst_ni && in_valid && in_ready_o;
    if (rst_ni && in_valid && in_ready_o) begin
      expected_outcomes.push_back(execute_request(pending_requests[0]));
      void'(pending_requests.pop_front());
      items_taken++;
    end
    if (rst_ni && out_valid_o && out_ready) begin
      got.pc = next_pc_o;
      got.idx = index_value_o;
      got.rdata = read_value_o;
      got.status = status_o;
      if (expected_outcomes.size() == 0) begin
        want = '{default: '0};
        report_failure("unexpected result", want, got);
      end else begin
        want = expected_outcomes.pop_front();
        if (got.pc !== want.pc || got.idx !== want.idx ||
            got.rdata !== want.rdata || got.status !== want.status) begin
          report_failure("result mismatch", want, got);
        end
      end
    end
  end

endmodule

// ===== sim.f =====
hdl/vmx_pkg.sv
hdl/vm_instruction_execute_subset.sv
bench/tb_top.sv
